[design/acpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acpp_pkg
// Shared types and constants for the axis conditioning to PPM pulse block.
// ----------------------------------------------------------------------------
package acpp_pkg;

  typedef enum logic [2:0] {
    CFG_TRIM   = 3'd0,
    CFG_DEAD   = 3'd1,
    CFG_EXPO   = 3'd2,
    CFG_CENTER = 3'd3,
    CFG_HALF   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  trim;
    logic [6:0]  dead;
    logic [7:0]  expo;
    logic [11:0] center;
    logic [10:0] half;
  } cfg_t;

  localparam logic [6:0]  DEAD_ZONE_CAP = 7'd95;
  localparam logic [6:0]  DEAD_ZONE_DIV = 7'd100;
  localparam logic signed [7:0] EXPO_LIMIT = 8'sd100;
  localparam logic [11:0] CENTER_RST    = 12'd1500;
  localparam logic [10:0] HALF_RST      = 11'd500;
  localparam logic [11:0] PULSE_LIMIT   = 12'd4095;

endpackage
`default_nettype wire

[design/acpp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acpp_front
// Accepts a raw sample with its range, centers it and flags an empty range
// or a saturating sample ahead of the division.
// ----------------------------------------------------------------------------
module acpp_front #(
  parameter int S = 16,
  parameter int F = 15,
  parameter int W = 2 * S + F + 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic signed [S-1:0] raw_sample,
  input  wire logic signed [S-1:0] range_min,
  input  wire logic signed [S-1:0] range_max,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [W-1:0]        out_data
);

  localparam int AW = S + 1 + F;

  logic signed [S+1:0] n_c;
  logic signed [S:0]   diff_c;
  logic [S-1:0]        span_c;
  logic [S:0]          nmag_c;
  logic [AW-1:0]       a_c;
  logic                zero_c;
  logic                sat_c;

  always_comb begin
    n_c    = ((S+2)'(raw_sample) <<< 1) - (S+2)'(range_min) - (S+2)'(range_max);
    diff_c = (S+1)'(range_max) - (S+1)'(range_min);
    span_c = diff_c[S] ? S'(-diff_c) : S'(diff_c);
    nmag_c = n_c[S+1] ? (S+1)'(-n_c) : (S+1)'(n_c);
    zero_c = (span_c < S'(2));
    sat_c  = (nmag_c >= {1'b0, span_c});
    // Rounding offset of half the divisor is folded into the dividend.
    a_c    = AW'({nmag_c, {F{1'b0}}}) + AW'(span_c[S-1:1]);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= {a_c, span_c, n_c[S+1], zero_c, sat_c};
    end
  end

endmodule
`default_nettype wire

[design/acpp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acpp_queue
// Two-entry queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module acpp_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output      logic         in_ready,
  input  wire logic [W-1:0] in_data,
  output      logic         out_valid,
  input  wire logic         out_ready,
  output      logic [W-1:0] out_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule
`default_nettype wire

[design/acpp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acpp_back
// Pipelined datapath: restoring divider, trim, dead zone, expo curve and
// pulse mapping. The whole pipeline advances while the output can move.
// ----------------------------------------------------------------------------
module acpp_back
  import acpp_pkg::*;
#(
  parameter int S = 16,
  parameter int F = 15,
  parameter int W = 2 * S + F + 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire logic         in_valid,
  output      logic         in_ready,
  input  wire logic [W-1:0] in_data,
  output      logic         out_valid,
  input  wire logic         out_ready,
  output      logic [15:0]  normalized_q15,
  output      logic [15:0]  shaped_q15,
  output      logic [11:0]  pulse_width_us
);

  localparam int AW   = S + 1 + F;
  localparam int QW   = F + 1;
  localparam int ND   = F + 2;
  localparam int NP   = 12;
  localparam int KZ   = F + 7;
  localparam int RZW  = F + 5;
  localparam int K2   = F + 8;
  localparam longint ONE  = longint'(1) << F;
  localparam longint QMAX = ONE - 1;
  localparam longint R100 = (longint'(1) << K2) / 100;

  // Pipeline positions after the divider.
  localparam int P_N  = 0;
  localparam int P_T  = 1;
  localparam int P_Z1 = 2;
  localparam int P_Z2 = 3;
  localparam int P_Z3 = 4;
  localparam int P_E1 = 5;
  localparam int P_E2 = 6;
  localparam int P_E3 = 7;
  localparam int P_E4 = 8;
  localparam int P_E5 = 9;
  localparam int P_E6 = 10;
  localparam int P_P1 = 11;

  logic adv;
  logic [ND-1:0] dv;
  logic [NP-1:0] pv;

  // Constant tables: trim offset per code and dead-zone reciprocals.
  logic signed [F+1:0] trim_tab [256];
  logic [RZW-1:0]      rz_tab [96];

  for (genvar i = 0; i < 256; i++) begin : g_trim
    localparam longint TN = longint'((i >= 128) ? i - 256 : i) * ONE;
    localparam longint TV = (TN < 0) ? -((-TN + 50) / 100) : (TN + 50) / 100;
    assign trim_tab[i] = (F+2)'(TV);
  end

  for (genvar i = 0; i < 96; i++) begin : g_rz
    localparam longint RZ = (longint'(1) << KZ) / (100 - i);
    assign rz_tab[i] = RZW'(RZ);
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Divider stage registers.
  logic [S-1:0] d_rem  [ND];
  logic [F:0]   d_ab   [ND];
  logic [F:0]   d_quo  [ND];
  logic [S-1:0] d_span [ND];
  logic         d_neg  [ND];
  logic         d_zero [ND];
  logic         d_sat  [ND];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rem[0]  <= in_data[W-1 -: S];
      d_ab[0]   <= in_data[S+3 +: F+1];
      d_quo[0]  <= '0;
      d_span[0] <= in_data[3 +: S];
      d_neg[0]  <= in_data[2];
      d_zero[0] <= in_data[1];
      d_sat[0]  <= in_data[0];
    end
  end

  for (genvar i = 1; i < ND; i++) begin : g_div
    logic [S:0] rs;
    logic       ge;
    assign rs = {d_rem[i-1], d_ab[i-1][F]};
    assign ge = (rs >= {1'b0, d_span[i-1]});
    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem[i]  <= ge ? S'(rs - {1'b0, d_span[i-1]}) : S'(rs);
        d_ab[i]   <= d_ab[i-1] << 1;
        d_quo[i]  <= {d_quo[i-1][F-1:0], ge};
        d_span[i] <= d_span[i-1];
        d_neg[i]  <= d_neg[i-1];
        d_zero[i] <= d_zero[i-1];
        d_sat[i]  <= d_sat[i-1];
      end
    end
  end

  // Normalized value travels alongside the shaping stages.
  logic signed [QW-1:0] norm_d [NP];

  logic [F-1:0]         n_mag_c;
  logic signed [F+2:0]  t_sum_c;
  logic                 t_neg;
  logic [F-1:0]         t_mag;

  logic [6:0]           dzv_c;
  logic [6:0]           dd_c;
  logic [F+6:0]         prod_m_c;
  logic [F+6:0]         thr_c;
  logic [F+6:0]         z1_x;
  logic [6:0]           z1_d;
  logic [RZW-1:0]       z1_r;
  logic                 z1_in_dz;
  logic                 z1_neg;
  logic [2*F+11:0]      z2_prod_c;
  logic [F+6:0]         z2_x;
  logic [6:0]           z2_d;
  logic [F-1:0]         z2_q0;
  logic                 z2_in_dz;
  logic                 z2_neg;
  logic [F+6:0]         z3_r_c;
  logic [F-1:0]         z3_q_c;
  logic signed [QW-1:0] z3_v;

  logic [F-1:0]         e1_vm_c;
  logic [2*F-1:0]       e1_sq_c;
  logic [F-1:0]         e1_v2;
  logic signed [QW-1:0] e1_v;
  logic [F-1:0]         e2_vm_c;
  logic [2*F-1:0]       e2_p3_c;
  logic signed [QW-1:0] e2_v3;
  logic signed [QW-1:0] e2_v;
  logic signed [7:0]    expo_s_c;
  logic signed [7:0]    ec_c;
  logic signed [F+1:0]  dlt_c;
  logic signed [F+9:0]  e3_prod_c;
  logic [F+7:0]         e3_y;
  logic                 e3_neg;
  logic signed [QW-1:0] e3_v;
  logic [F+7:0]         e4_x_c;
  logic [2*F+9:0]       e4_prod_c;
  logic [F+7:0]         e4_x;
  logic [F+1:0]         e4_q0;
  logic                 e4_neg;
  logic signed [QW-1:0] e4_v;
  logic [F+7:0]         e5_r_c;
  logic [F+1:0]         e5_q;
  logic                 e5_neg;
  logic signed [QW-1:0] e5_v;
  logic signed [F+2:0]  e6_sum_c;
  logic signed [F+2:0]  e6_off_c;
  logic signed [QW-1:0] e6_s;
  logic signed [QW-1:0] shaped_hold;

  logic [F-1:0]         p1_sm_c;
  logic [F+10:0]        p1_prod_c;
  logic [10:0]          p1_pm;
  logic                 p1_neg;
  logic signed [13:0]   p2_sum_c;
  logic [11:0]          p2_pulse_c;
  logic signed [31:0]   norm32_c;
  logic signed [31:0]   shaped32_c;

  always_comb begin
    // N: saturate the quotient and apply the sign.
    if (d_zero[ND-1]) begin
      n_mag_c = '0;
    end else if (d_sat[ND-1] || d_quo[ND-1][F]) begin
      n_mag_c = F'(QMAX);
    end else begin
      n_mag_c = d_quo[ND-1][F-1:0];
    end

    // T: trim and clamp.
    t_sum_c = (F+3)'(norm_d[P_N]) + (F+3)'(trim_tab[cfg.trim]);

    // Z1: dead zone threshold and rescale numerator.
    dzv_c    = (cfg.dead > DEAD_ZONE_CAP) ? DEAD_ZONE_CAP : cfg.dead;
    dd_c     = DEAD_ZONE_DIV - dzv_c;
    prod_m_c = (F+7)'(t_mag) * (F+7)'(100);
    thr_c    = (F+7)'(dzv_c) << F;

    // Z2/Z3: reciprocal multiply, then one correction step.
    z2_prod_c = (2*F+12)'(z1_x) * (2*F+12)'(z1_r);
    z3_r_c    = z2_x - (F+7)'(z2_q0) * (F+7)'(z2_d);
    z3_q_c    = (z3_r_c >= (F+7)'(z2_d)) ? z2_q0 + F'(1) : z2_q0;

    // E1/E2: square and cube with rounding half away from zero.
    e1_vm_c = z3_v[QW-1] ? F'(-z3_v) : F'(z3_v);
    e1_sq_c = (2*F)'(e1_vm_c) * (2*F)'(e1_vm_c) + ((2*F)'(1) << (F - 1));
    e2_vm_c = e1_v[QW-1] ? F'(-e1_v) : F'(e1_v);
    e2_p3_c = (2*F)'(e1_v2) * (2*F)'(e2_vm_c) + ((2*F)'(1) << (F - 1));

    // E3: weighted difference of cube and linear term.
    expo_s_c = $signed(cfg.expo);
    if (expo_s_c > EXPO_LIMIT) begin
      ec_c = EXPO_LIMIT;
    end else if (expo_s_c < -EXPO_LIMIT) begin
      ec_c = -EXPO_LIMIT;
    end else begin
      ec_c = expo_s_c;
    end
    dlt_c     = (F+2)'(e2_v3) - (F+2)'(e2_v);
    e3_prod_c = (F+10)'(ec_c) * (F+10)'(dlt_c);

    // E4/E5: divide by 100 through a reciprocal and a correction.
    e4_x_c    = e3_y + (F+8)'(50);
    e4_prod_c = (2*F+10)'(e4_x_c) * (2*F+10)'(R100);
    e5_r_c    = e4_x - (F+8)'(e4_q0) * (F+8)'(100);

    // E6: add and clamp.
    e6_off_c = $signed({1'b0, e5_q});
    e6_sum_c = (F+3)'(e5_v) + (e5_neg ? -e6_off_c : e6_off_c);

    // P1/P2: scale by half range and offset by the center.
    p1_sm_c   = e6_s[QW-1] ? F'(-e6_s) : F'(e6_s);
    p1_prod_c = (F+11)'(p1_sm_c) * (F+11)'(cfg.half) + ((F+11)'(1) << (F - 1));
    p2_sum_c  = p1_neg ? $signed({2'b00, cfg.center}) - $signed({3'b000, p1_pm})
                       : $signed({2'b00, cfg.center}) + $signed({3'b000, p1_pm});
    if (p2_sum_c < 14'sd0) begin
      p2_pulse_c = '0;
    end else if (p2_sum_c > $signed({2'b00, PULSE_LIMIT})) begin
      p2_pulse_c = PULSE_LIMIT;
    end else begin
      p2_pulse_c = p2_sum_c[11:0];
    end

    norm32_c   = 32'(norm_d[P_P1]);
    shaped32_c = 32'(shaped_hold);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_d[P_N] <= d_neg[ND-1] ? -$signed({1'b0, n_mag_c}) : $signed({1'b0, n_mag_c});
      for (int k = 1; k < NP; k++) begin
        norm_d[k] <= norm_d[k-1];
      end

      t_neg <= t_sum_c[F+2];
      if (t_sum_c > (F+3)'(QMAX) || t_sum_c < -(F+3)'(QMAX)) begin
        t_mag <= F'(QMAX);
      end else begin
        t_mag <= t_sum_c[F+2] ? F'(-t_sum_c) : F'(t_sum_c);
      end

      z1_x     <= prod_m_c - thr_c + (F+7)'(dd_c[6:1]);
      z1_d     <= dd_c;
      z1_r     <= rz_tab[dzv_c];
      z1_in_dz <= (prod_m_c <= thr_c);
      z1_neg   <= t_neg;

      z2_x     <= z1_x;
      z2_d     <= z1_d;
      z2_q0    <= z2_prod_c[KZ +: F];
      z2_in_dz <= z1_in_dz;
      z2_neg   <= z1_neg;

      if (z2_in_dz) begin
        z3_v <= '0;
      end else begin
        z3_v <= z2_neg ? -$signed({1'b0, z3_q_c}) : $signed({1'b0, z3_q_c});
      end

      e1_v2 <= e1_sq_c[F +: F];
      e1_v  <= z3_v;

      e2_v3 <= e1_v[QW-1] ? -$signed({1'b0, e2_p3_c[F +: F]})
                          : $signed({1'b0, e2_p3_c[F +: F]});
      e2_v  <= e1_v;

      e3_neg <= e3_prod_c[F+9];
      e3_y   <= e3_prod_c[F+9] ? (F+8)'(-e3_prod_c) : (F+8)'(e3_prod_c);
      e3_v   <= e2_v;

      e4_x   <= e4_x_c;
      e4_q0  <= e4_prod_c[K2 +: F+2];
      e4_neg <= e3_neg;
      e4_v   <= e3_v;

      e5_q   <= (e5_r_c >= (F+8)'(100)) ? e4_q0 + (F+2)'(1) : e4_q0;
      e5_neg <= e4_neg;
      e5_v   <= e4_v;

      if (e6_sum_c > (F+3)'(QMAX)) begin
        e6_s <= QW'(QMAX);
      end else if (e6_sum_c < -(F+3)'(QMAX)) begin
        e6_s <= -QW'(QMAX);
      end else begin
        e6_s <= QW'(e6_sum_c);
      end

      p1_pm  <= p1_prod_c[F +: 11];
      p1_neg <= e6_s[QW-1];

      normalized_q15 <= norm32_c[15:0];
      shaped_q15     <= shaped32_c[15:0];
      pulse_width_us <= p2_pulse_c;
    end
  end

  // Shaped value has to be carried one stage further to line up with P1.
  always_ff @(posedge clk) begin
    if (adv) begin
      shaped_hold <= e6_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv        <= '0;
      pv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      dv        <= {dv[ND-2:0], in_valid};
      pv        <= {pv[NP-2:0], dv[ND-1]};
      out_valid <= pv[P_P1];
    end
  end

  // Quotient stays within one unit above full scale unless flagged.
  assert property (@(posedge clk) disable iff (rst)
    dv[ND-1] && !d_sat[ND-1] && !d_zero[ND-1] |-> d_quo[ND-1] <= (F+1)'(ONE))
    else $error("divider quotient out of range");

  // Reciprocal estimate is off by at most one for the dead-zone rescale.
  assert property (@(posedge clk) disable iff (rst)
    pv[P_Z2] && !z2_in_dz |-> z3_r_c < ((F+7)'(z2_d) << 1))
    else $error("dead zone correction out of range");

  // Same for the divide by 100 in the expo blend.
  assert property (@(posedge clk) disable iff (rst)
    pv[P_E4] |-> e5_r_c < (F+8)'(200))
    else $error("expo correction out of range");

  // A stalled output freezes every stage.
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dv) && $stable(pv))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

[design/axis_condition_to_ppm_pulse.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_condition_to_ppm_pulse
// Conditions a stick axis sample (center, scale, trim, dead zone, expo) and
// maps it to a PPM pulse width.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// s_axis    in         raw_sample, range_min, range_max
// m_axis    out        normalized_q15, shaped_q15, pulse_width_us
// cfg       in         register index and write data
//
// One item per cycle is sustained while the output is not stalled; a result
// passes through the front register, the queue, the one-bit-per-stage
// divider and the shaping pipeline.
// Reset clears all valid flags and loads the register defaults.
// A stalled output freezes the back pipeline; the two-entry queue lets the
// front keep taking requests until it fills.
// ----------------------------------------------------------------------------
module axis_condition_to_ppm_pulse
  import acpp_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     s_axis_tvalid,
  output      logic                                     s_axis_tready,
  // raw_sample, range_min, range_max from bit 0 up, zero padded to bytes
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output      logic                                     m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // normalized_q15, shaped_q15, pulse_width_us from bit 0 up, zero padded
  output      logic [47:0]                              m_axis_tdata,
  input  wire logic                                     cfg_valid,
  output      logic                                     cfg_ready,
  input  wire logic [2:0]                               cfg_index,
  input  wire logic [11:0]                              cfg_data
);

  localparam int S = SAMPLE_BITS;
  localparam int F = FRACTION_BITS;
  localparam int W = 2 * S + F + 4;

  cfg_t cfg;

  logic         f_valid;
  logic         f_ready;
  logic [W-1:0] f_data;
  logic         q_valid;
  logic         q_ready;
  logic [W-1:0] q_data;
  logic [15:0]  normalized_q15;
  logic [15:0]  shaped_q15;
  logic [11:0]  pulse_width_us;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trim   <= '0;
      cfg.dead   <= '0;
      cfg.expo   <= '0;
      cfg.center <= CENTER_RST;
      cfg.half   <= HALF_RST;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_TRIM:   cfg.trim   <= cfg_data[7:0];
        CFG_DEAD:   cfg.dead   <= cfg_data[6:0];
        CFG_EXPO:   cfg.expo   <= cfg_data[7:0];
        CFG_CENTER: cfg.center <= cfg_data;
        CFG_HALF:   cfg.half   <= cfg_data[10:0];
        default:    cfg        <= cfg;
      endcase
    end
  end

  acpp_front #(.S(S), .F(F), .W(W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .raw_sample ($signed(s_axis_tdata[0 +: S])),
    .range_min  ($signed(s_axis_tdata[S +: S])),
    .range_max  ($signed(s_axis_tdata[2*S +: S])),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_data   (f_data)
  );

  acpp_queue #(.W(W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  acpp_back #(.S(S), .F(F), .W(W)) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (q_valid),
    .in_ready       (q_ready),
    .in_data        (q_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .normalized_q15 (normalized_q15),
    .shaped_q15     (shaped_q15),
    .pulse_width_us (pulse_width_us)
  );

  assign m_axis_tdata = {4'b0000, pulse_width_us, shaped_q15, normalized_q15};

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raw axis samples with their ranges through the stick conditioning
// block under several register settings, predicts every pulse result and
// compares it field by field in arrival order, with random gaps and stalls.
// ----------------------------------------------------------------------------

class pulse_scoreboard;
  logic [47:0] pending[$];
  int errors;

  function void note_request(logic [47:0] exp_word);
    pending.push_back(exp_word);
  endfunction

  function void check_result(logic [47:0] got);
    logic [47:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got[15:0] !== want[15:0]) begin
      $display("%0t: normalized expected %h actual %h", $time, want[15:0], got[15:0]);
      errors++;
    end
    if (got[31:16] !== want[31:16]) begin
      $display("%0t: shaped expected %h actual %h", $time, want[31:16], got[31:16]);
      errors++;
    end
    if (got[47:32] !== want[47:32]) begin
      $display("%0t: pulse expected %h actual %h", $time, want[47:32], got[47:32]);
      errors++;
    end
  endfunction
endclass

module tb_top
  import acpp_pkg::*;
();

  // An index past the last register; writes to it are ignored.
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  pulse_scoreboard sb = new();

  logic [7:0]  trim_reg = 8'd0;
  logic [6:0]  dead_reg = 7'd0;
  logic [7:0]  expo_reg = 8'd0;
  logic [11:0] center_reg = 12'd1500;
  logic [10:0] half_reg = 11'd500;

  int  cycles = 0;
  bit  hold_off = 0;
  bit  sink_burst = 0;

  axis_condition_to_ppm_pulse u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint rnd_div(longint num, longint den);
    if (num < 0) return -((-num + den / 2) / den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [47:0] pulse_of(logic [15:0] raw_w, logic [15:0] lo_w,
                                           logic [15:0] hi_w);
    longint one, qmax, raw, lo, hi, span, norm, v, mag, dz, e, v2, v3, c, h, p;
    logic [47:0] r;
    one = 32768;
    qmax = one - 1;
    raw = longint'($signed(raw_w));
    lo = longint'($signed(lo_w));
    hi = longint'($signed(hi_w));
    span = hi - lo;
    if (span < 0) span = -span;
    norm = 0;
    if (span >= 2) norm = clip(rnd_div((2 * raw - lo - hi) * one, span), -qmax, qmax);
    v = clip(norm + rnd_div(longint'($signed(trim_reg)) * one, 100), -qmax, qmax);
    dz = longint'(dead_reg);
    if (dz > 95) dz = 95;
    mag = v < 0 ? -v : v;
    if (mag * 100 <= dz * one) begin
      v = 0;
    end else begin
      mag = rnd_div(mag * 100 - dz * one, 100 - dz);
      v = v < 0 ? -mag : mag;
    end
    e = clip(longint'($signed(expo_reg)), -100, 100);
    v2 = rnd_div(v * v, one);
    v3 = rnd_div(v2 * v, one);
    v = clip(v + rnd_div(e * (v3 - v), 100), -qmax, qmax);
    c = longint'(center_reg);
    h = longint'(half_reg);
    p = clip(c + rnd_div(v * h, one), c - h, c + h);
    p = clip(p, 0, 4095);
    r = '0;
    r[15:0] = norm[15:0];
    r[31:16] = v[15:0];
    r[43:32] = p[11:0];
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TRIM:   trim_reg = val[7:0];
      CFG_DEAD:   dead_reg = val[6:0];
      CFG_EXPO:   expo_reg = val[7:0];
      CFG_CENTER: center_reg = val;
      CFG_HALF:   half_reg = val[10:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [15:0] raw, logic [15:0] lo, logic [15:0] hi);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hi, lo, raw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(pulse_of(raw, lo, hi));
    // Keep valid high when the next request follows without a gap.
    begin
      int g;
      g = gap_len();
      if (g > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_burst(int n);
    logic [15:0] lo, hi, raw;
    int mode;
    repeat (n) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        lo = 16'($urandom_range(0, 65535));
        hi = 16'($urandom_range(0, 65535));
        raw = 16'($urandom_range(0, 65535));
      end else if (mode < 8) begin
        lo = -16'sd2048;
        hi = 16'd2047;
        raw = 16'($urandom_range(0, 4095)) - 16'd2048;
      end else if (mode == 8) begin
        lo = 16'($urandom_range(0, 65535));
        hi = lo + 16'($urandom_range(0, 2)) - 16'd1;
        raw = 16'($urandom_range(0, 65535));
      end else begin
        lo = 16'd0;
        hi = 16'd1023;
        raw = 16'($urandom_range(0, 1023));
      end
      send_sample(raw, lo, hi);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Output side: random stalls, with a long hold-off stretch on request.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      g = sink_burst ? 0 : gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, empty and tiny ranges, reversed range.
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'h8000, 16'h7FFF);
    send_sample(16'h1234, 16'h0100, 16'h0100);
    send_sample(16'h0101, 16'h0100, 16'h0101);
    send_sample(16'h0000, 16'h0100, 16'h0102);
    send_sample(16'h7FFF, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7FFF, 16'h7FFF);
    send_sample(16'h0010, 16'h0064, 16'hFF9C);
    send_sample(16'h7FFF, 16'h7FFF, 16'h8000);
    send_sample(16'hFFFF, 16'h0000, 16'h00FF);
    drain();

    // Trim beyond limits, dead zone above the cap, expo saturated.
    write_reg(CFG_TRIM, 12'h07F);
    write_reg(CFG_DEAD, 12'h07F);
    write_reg(CFG_EXPO, 12'h080);
    write_reg(CFG_CENTER, 12'd100);
    write_reg(CFG_HALF, 12'd2047);
    send_sample(16'h0000, 16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    random_burst(40);
    drain();

    write_reg(CFG_TRIM, 12'h080);
    write_reg(CFG_DEAD, 12'd95);
    write_reg(CFG_EXPO, 12'h07F);
    write_reg(CFG_CENTER, 12'hFFF);
    write_reg(CFG_HALF, 12'd0);
    write_reg(cfg_index_t'(CFG_UNUSED), 12'hABC);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h7FFF);
    random_burst(40);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    write_reg(CFG_TRIM, 12'hFF6);
    write_reg(CFG_DEAD, 12'd10);
    write_reg(CFG_EXPO, 12'd50);
    write_reg(CFG_CENTER, 12'd1500);
    write_reg(CFG_HALF, 12'd500);
    hold_off = 1;
    random_burst(120);
    drain();

    repeat (6) begin
      write_reg(CFG_TRIM, 12'($urandom_range(0, 255)));
      write_reg(CFG_DEAD, 12'($urandom_range(0, 127)));
      write_reg(CFG_EXPO, 12'($urandom_range(0, 255)));
      write_reg(CFG_CENTER, 12'($urandom_range(0, 4095)));
      write_reg(CFG_HALF, 12'($urandom_range(0, 2047)));
      sink_burst = $urandom_range(0, 1);
      random_burst(60);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[axis_condition_to_ppm_pulse.f]
design/acpp_pkg.sv
design/acpp_front.sv
design/acpp_queue.sv
design/acpp_back.sv
design/axis_condition_to_ppm_pulse.sv
dv/tb_top.sv
